### rtl/lpt_pkg.sv
// lpt_pkg: shared constants, codes and types of the loop event table
// used by lpt_front, lpt_back and loop_event_table
package lpt_pkg;

  localparam int Capacity      = 32;
  localparam int IdxW          = $clog2(Capacity);
  localparam int CntW          = IdxW + 1;
  localparam int PosW          = 13;
  localparam int NoteW         = 8;
  localparam int StepsW        = 7;
  localparam int PulsesPerStep = 96;
  localparam int EndBuffer     = 4;
  localparam int MaxLoopSteps  = 64;
  localparam int LoopEndW      = StepsW + 7;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] KIND_KEEP   = 2'd0;
  localparam logic [1:0] KIND_CHOSEN = 2'd1;
  localparam logic [1:0] KIND_FIRST  = 2'd2;

  typedef struct packed {
    logic [PosW-1:0]  s;
    logic [PosW-1:0]  e;
    logic [NoteW-1:0] n;
    logic             c;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic [1:0]       mode;
    logic [PosW-1:0]  pos;
    logic [PosW-1:0]  st;
    logic [PosW-1:0]  en;
    logic [NoteW-1:0] note;
    logic             chord;
  } cmd_t;

  typedef struct packed {
    logic             active;
    logic [NoteW-1:0] note;
    logic             chord;
    logic [CntW-1:0]  count;
    logic             dropped;
  } res_t;

endpackage

### rtl/lpt_ram.sv
// lpt_ram: generic single write port ram with registered read
// no dependencies
module lpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/lpt_front.sv
// lpt_front: loop length register, item decode with end fix-up, command queue
// depends on lpt_pkg
module lpt_front import lpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              steps_we_i,
  input  logic [StepsW-1:0] steps_i,
  input  logic              push_i,
  output logic              full_o,
  input  logic [1:0]        mode_i,
  input  logic [PosW-1:0]   position_i,
  input  logic [PosW-1:0]   start_i,
  input  logic [PosW-1:0]   end_i,
  input  logic [NoteW-1:0]  note_i,
  input  logic              chord_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  logic [StepsW-1:0]   steps_q;
  logic [StepsW-1:0]   steps_c;
  logic [LoopEndW-1:0] prod;
  logic [LoopEndW-1:0] le_w;
  logic [PosW-1:0]     loop_end;
  logic [PosW:0]       buf_end;
  logic [PosW-1:0]     en_fix;
  cmd_t                cmd_in;
  cmd_t                fifo_q [2];
  logic                wp_q, rp_q;
  logic [1:0]          cnt_q;
  logic                do_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= StepsW'(16);
    end else if (steps_we_i) begin
      steps_q <= steps_i;
    end
  end

  always_comb begin
    if (steps_q == '0) begin
      steps_c = StepsW'(1);
    end else if (steps_q > StepsW'(MaxLoopSteps)) begin
      steps_c = StepsW'(MaxLoopSteps);
    end else begin
      steps_c = steps_q;
    end
    prod = LoopEndW'(steps_c) * LoopEndW'(PulsesPerStep);
    le_w = prod - LoopEndW'(1);
    loop_end = (le_w > LoopEndW'((1 << PosW) - 1)) ? '1 : le_w[PosW-1:0];
    buf_end = {1'b0, start_i} + (PosW+1)'(EndBuffer);
    if (end_i < start_i) begin
      en_fix = loop_end;
    end else if (end_i == start_i) begin
      en_fix = (buf_end > {1'b0, loop_end}) ? loop_end : buf_end[PosW-1:0];
    end else begin
      en_fix = end_i;
    end
    cmd_in = '{mode: mode_i, pos: position_i, st: start_i, en: en_fix,
               note: note_i, chord: chord_i};
  end

  assign full_o      = (cnt_q == 2'd2);
  assign do_push     = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wp_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wp_q <= ~wp_q;
      end
      if (cmd_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(cmd_pop_i);
    end
  end

endmodule

### rtl/lpt_back.sv
// lpt_back: table sequencer over two ping-pong rams, playback pointer, result queue
// depends on lpt_pkg and lpt_ram
module lpt_back import lpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DO   = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_PROC = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_LDA  = 3'd5;
  localparam logic [2:0] S_LDD  = 3'd6;
  localparam logic [2:0] S_RES  = 3'd7;

  logic [2:0]      state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [CntW-1:0] count_q, count_d, m_q, m_d;
  logic [IdxW-1:0] qidx_q, qidx_d, i_q, i_d, chosen_q, chosen_d;
  logic [IdxW-1:0] posq_q, posq_d, posn_q, posn_d, posc_q, posc_d;
  logic            trig_q, trig_d, bank_q, bank_d, drop_q, drop_d;
  logic            placed_q, placed_d, qrem_q, qrem_d, org0_q, org0_d;
  logic [1:0]      kind_q, kind_d;
  entry_t          cache_q, cache_d;

  logic            we, wbank;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, cur, nv;
  logic [EntryW-1:0] rdata_a, rdata_b;

  res_t            ofifo_q [2];
  logic            owp_q, orp_q;
  logic [1:0]      ocnt_q;
  logic            opush;
  res_t            res_new;
  logic [CntW-1:0] i1, m_f;
  logic [IdxW-1:0] posn_f, nq, nxt;
  logic            clr;

  lpt_ram #(.Width(EntryW), .Depth(Capacity)) u_ram_a (
    .clk_i, .we_i(we && !wbank), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata_a)
  );

  lpt_ram #(.Width(EntryW), .Depth(Capacity)) u_ram_b (
    .clk_i, .we_i(we && wbank), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata_b)
  );

  assign cur = bank_q ? entry_t'(rdata_b) : entry_t'(rdata_a);
  assign nv  = '{s: cmd_q.st, e: cmd_q.en, n: cmd_q.note, c: cmd_q.chord};
  assign i1  = {1'b0, i_q} + CntW'(1);

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; count_d = count_q; m_d = m_q;
    qidx_d = qidx_q; i_d = i_q; chosen_d = chosen_q;
    posq_d = posq_q; posn_d = posn_q; posc_d = posc_q;
    trig_d = trig_q; bank_d = bank_q; drop_d = drop_q;
    placed_d = placed_q; qrem_d = qrem_q; org0_d = org0_q;
    kind_d = kind_q; cache_d = cache_q;
    we = 1'b0; wbank = ~bank_q; waddr = m_q[IdxW-1:0]; wdata = cur;
    raddr = i_q; cmd_pop_o = 1'b0; opush = 1'b0;
    m_f = m_q; posn_f = posn_q; nq = '0; clr = 1'b0;
    nxt = (i1 == count_q) ? '0 : i1[IdxW-1:0];
    if (qidx_q == IdxW'(count_q - CntW'(1))) begin
      nxt = '0;
    end else begin
      nxt = qidx_q + IdxW'(1);
    end
    res_new = '{active: trig_q,
                note: (count_q != '0) ? cache_q.n : '0,
                chord: (count_q != '0) ? cache_q.c : 1'b0,
                count: count_q, dropped: drop_q};

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && ocnt_q != 2'd2) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          drop_d    = 1'b0;
          state_d   = S_DO;
        end
      end
      S_DO: begin
        state_d = S_RES;
        case (cmd_q.mode)
          MODE_TICK: begin
            if (count_q != '0) begin
              if (!trig_q) begin
                if (cmd_q.pos == cache_q.s) trig_d = 1'b1;
              end else if (cmd_q.pos == cache_q.e) begin
                trig_d  = 1'b0;
                qidx_d  = nxt;
                state_d = S_LDA;
              end
            end
          end
          MODE_ADD: begin
            if (count_q >= CntW'(Capacity)) begin
              drop_d = 1'b1;
            end else if (count_q == '0) begin
              we      = 1'b1;
              wbank   = bank_q;
              waddr   = '0;
              wdata   = nv;
              count_d = CntW'(1);
              qidx_d  = '0;
              trig_d  = 1'b0;
              cache_d = nv;
            end else begin
              i_d = '0; m_d = '0; placed_d = 1'b0; qrem_d = 1'b0;
              org0_d = 1'b0; kind_d = KIND_KEEP; chosen_d = '0;
              posq_d = '0; posn_d = '0; posc_d = '0;
              state_d = S_RD;
            end
          end
          MODE_CLEAR: begin
            count_d = '0;
            qidx_d  = '0;
            trig_d  = 1'b0;
          end
          default: ;
        endcase
      end
      S_RD: begin
        state_d = S_PROC;
      end
      S_PROC: begin
        if (!placed_q && cmd_q.st <= cur.s && cmd_q.en < cur.s) begin
          we       = 1'b1;
          wdata    = nv;
          posn_d   = m_q[IdxW-1:0];
          m_d      = m_q + CntW'(1);
          placed_d = 1'b1;
        end else begin
          if (!placed_q && cmd_q.st <= cur.s) begin
            if (i_q == qidx_q) qrem_d = 1'b1;
            if (i_q != '0) begin
              if (i1 < count_q) begin
                kind_d   = KIND_CHOSEN;
                chosen_d = i1[IdxW-1:0];
              end else begin
                kind_d = KIND_FIRST;
              end
            end
          end else begin
            if (!placed_q && cmd_q.st <= cur.e) begin
              wdata.e = cmd_q.st - PosW'(1);
              if (i1 == count_q) kind_d = KIND_FIRST;
            end
            we  = 1'b1;
            m_d = m_q + CntW'(1);
            if (i_q == qidx_q) begin
              posq_d = m_q[IdxW-1:0];
              if (m_q == '0) org0_d = 1'b1;
            end
            if (kind_q == KIND_CHOSEN && i_q == chosen_q) posc_d = m_q[IdxW-1:0];
          end
          if (i1 == count_q) begin
            state_d = S_FIN;
          end else begin
            i_d     = i1[IdxW-1:0];
            state_d = S_RD;
          end
        end
      end
      S_FIN: begin
        if (!placed_q) begin
          we     = 1'b1;
          wdata  = nv;
          m_f    = m_q + CntW'(1);
          posn_f = m_q[IdxW-1:0];
        end
        if (kind_q == KIND_FIRST) begin
          nq  = '0;
          clr = !org0_q;
        end else if (kind_q == KIND_CHOSEN) begin
          nq  = posc_q;
          clr = (chosen_q != qidx_q);
        end else if (qrem_q) begin
          nq  = posn_f;
          clr = 1'b1;
        end else begin
          nq  = posq_q;
          clr = 1'b0;
        end
        if (clr) trig_d = 1'b0;
        count_d = m_f;
        qidx_d  = nq;
        bank_d  = ~bank_q;
        state_d = S_LDA;
      end
      S_LDA: begin
        raddr   = qidx_q;
        state_d = S_LDD;
      end
      S_LDD: begin
        raddr   = qidx_q;
        cache_d = cur;
        state_d = S_RES;
      end
      S_RES: begin
        opush   = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      qidx_q  <= '0;
      trig_q  <= 1'b0;
      bank_q  <= 1'b0;
      owp_q   <= 1'b0;
      orp_q   <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      qidx_q  <= qidx_d;
      trig_q  <= trig_d;
      bank_q  <= bank_d;
      if (opush) owp_q <= ~owp_q;
      if (pop_i && !empty_o) orp_q <= ~orp_q;
      ocnt_q <= ocnt_q + 2'(opush) - 2'(pop_i && !empty_o);
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    m_q      <= m_d;
    i_q      <= i_d;
    chosen_q <= chosen_d;
    posq_q   <= posq_d;
    posn_q   <= posn_d;
    posc_q   <= posc_d;
    drop_q   <= drop_d;
    placed_q <= placed_d;
    qrem_q   <= qrem_d;
    org0_q   <= org0_d;
    kind_q   <= kind_d;
    cache_q  <= cache_d;
    if (opush) ofifo_q[owp_q] <= res_new;
  end

  assign empty_o = (ocnt_q == 2'd0);
  assign res_o   = ofifo_q[orp_q];

endmodule

### rtl/loop_event_table.sv
// loop_event_table: top level of the loop event table
// depends on lpt_pkg, lpt_front and lpt_back
//
// usage: items enter through push/full, results leave through empty/pop,
// one result per item in item order. loop_steps_we_i writes the loop length
// in steps (reset 16); write it only while no item is in flight.
// mode 0 ticks the playback pointer at position_i, mode 1 adds an event,
// mode 2 clears the table, mode 3 leaves everything as it was.
// a two-entry command queue sits between the decode front and the table
// sequencer, and a two-entry result queue sits at the output, so input is
// taken while a result waits for pop.
// tick, clear and refused or first add pass S_DO then S_RES; a tick that
// advances the pointer reloads the cached event in S_LDA and S_LDD first. an
// add into a non-empty table passes S_RD and S_PROC per stored event, reading
// it from one ram bank and writing the merged table into the other.
// reset empties the table, sets the pointer to entry 0, untriggered, and
// empties both queues. when pop stays low the result queue fills, then the
// command queue, and full rises; nothing is lost.
module loop_event_table import lpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              loop_steps_we_i,
  input  logic [StepsW-1:0] loop_steps_i,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        mode_i,
  input  logic [PosW-1:0]   position_i,
  input  logic [PosW-1:0]   start_position_i,
  input  logic [PosW-1:0]   end_position_i,
  input  logic [NoteW-1:0]  note_value_i,
  input  logic              is_chord_i,
  output logic              empty,
  input  logic              pop,
  output logic              active_o,
  output logic [NoteW-1:0]  current_note_o,
  output logic              current_chord_o,
  output logic [CntW-1:0]   event_count_o,
  output logic              add_dropped_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  lpt_front u_front (
    .clk_i, .rst_ni,
    .steps_we_i(loop_steps_we_i), .steps_i(loop_steps_i),
    .push_i(push), .full_o(full),
    .mode_i, .position_i, .start_i(start_position_i), .end_i(end_position_i),
    .note_i(note_value_i), .chord_i(is_chord_i),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  lpt_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .pop_i(pop), .empty_o(empty), .res_o(res)
  );

  assign active_o        = res.active;
  assign current_note_o  = res.note;
  assign current_chord_o = res.chord;
  assign event_count_o   = res.count;
  assign add_dropped_o   = res.dropped;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> event_count_o <= CntW'(Capacity))
    else $error("event count above capacity");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && add_dropped_o) |-> event_count_o == CntW'(Capacity))
    else $error("add refused with room left");

  a_empty_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_count_o == '0) |-> (!active_o && current_note_o == '0))
    else $error("empty table reports an event");

  a_pop_empty_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command taken from empty queue");

endmodule

### dv/tb_top.sv
// tb_top: self-checking testbench for loop_event_table
// depends on lpt_pkg and the loop_event_table rtl; an internal table model predicts every result
`timescale 1ns / 1ps

module tb_top;
  import lpt_pkg::*;

  localparam logic [1:0] ModeIgnored = 2'd3;
  localparam int         TagNew      = -1;

  typedef struct {
    logic [1:0]       mode;
    logic [PosW-1:0]  pos;
    logic [PosW-1:0]  st;
    logic [PosW-1:0]  en;
    logic [NoteW-1:0] note;
    logic             chord;
  } item_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [StepsW-1:0] cfg_steps = '0;
  logic              push = 1'b0;
  logic              full;
  logic [1:0]        mode_d = MODE_TICK;
  logic [PosW-1:0]   pos_d = '0, st_d = '0, en_d = '0;
  logic [NoteW-1:0]  note_d = '0;
  logic              chord_d = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic              active_o, current_chord_o, add_dropped_o;
  logic [NoteW-1:0]  current_note_o;
  logic [CntW-1:0]   event_count_o;

  always #5 clk_i = ~clk_i;

  loop_event_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .loop_steps_we_i(cfg_we), .loop_steps_i(cfg_steps),
    .push(push), .full(full),
    .mode_i(mode_d), .position_i(pos_d), .start_position_i(st_d),
    .end_position_i(en_d), .note_value_i(note_d), .is_chord_i(chord_d),
    .empty(empty), .pop(pop),
    .active_o(active_o), .current_note_o(current_note_o),
    .current_chord_o(current_chord_o), .event_count_o(event_count_o),
    .add_dropped_o(add_dropped_o)
  );

  // table model state
  logic [PosW-1:0]  tbl_s [Capacity];
  logic [PosW-1:0]  tbl_e [Capacity];
  logic [NoteW-1:0] tbl_n [Capacity];
  logic             tbl_c [Capacity];
  int               tbl_count = 0;
  int               play_idx = 0;
  logic             playing = 1'b0;
  int               model_steps = 16;

  item_t pending_items[$];
  res_t  expected_status[$];
  int    errors = 0;
  int    n_checked = 0, n_active = 0, n_dropped = 0, n_full_tables = 0;

  function automatic int loop_end_pulses(int steps);
    int s;
    s = steps < 1 ? 1 : (steps > MaxLoopSteps ? MaxLoopSteps : steps);
    return s * PulsesPerStep - 1;
  endfunction

  function automatic logic insert_event(item_t it);
    logic [PosW-1:0]  ns [Capacity+1];
    logic [PosW-1:0]  ne [Capacity+1];
    logic [NoteW-1:0] nn [Capacity+1];
    logic             nc [Capacity+1];
    int               org [Capacity+1];
    int n, q, le, st, en, m, nq, want, chosen;
    logic placed, q_removed;
    logic [1:0] kind;
    n = tbl_count;
    q = play_idx;
    le = loop_end_pulses(model_steps);
    st = int'(it.st);
    en = int'(it.en);
    m = 0;
    placed = 1'b0;
    q_removed = 1'b0;
    kind = KIND_KEEP;
    chosen = 0;
    if (n >= Capacity) return 1'b1;
    if (en < st) en = le;
    else if (en == st) en = (st + EndBuffer > le) ? le : st + EndBuffer;
    if (n == 0) begin
      tbl_s[0] = PosW'(st); tbl_e[0] = PosW'(en); tbl_n[0] = it.note; tbl_c[0] = it.chord;
      tbl_count = 1;
      play_idx = 0;
      playing = 1'b0;
      return 1'b0;
    end
    if (q >= n) q = 0;
    for (int i = 0; i <= n; i++) begin
      logic [PosW-1:0] cs, ce;
      logic put_new, put_cur;
      put_new = 1'b0;
      put_cur = 1'b0;
      if (i == n) begin
        put_new = !placed;
      end else begin
        cs = tbl_s[i];
        ce = tbl_e[i];
        if (placed) begin
          put_cur = 1'b1;
        end else if (st <= cs) begin
          if (en < cs) begin
            put_new = 1'b1;
            put_cur = 1'b1;
          end else begin
            if (i == q) q_removed = 1'b1;
            if (i != 0) begin
              if (i + 1 < n) begin
                kind = KIND_CHOSEN;
                chosen = i + 1;
              end else begin
                kind = KIND_FIRST;
              end
            end
          end
        end else begin
          if (st <= ce) begin
            ce = PosW'(st - 1);
            if (i + 1 == n) kind = KIND_FIRST;
          end
          put_cur = 1'b1;
        end
      end
      if (put_new && m < Capacity + 1) begin
        ns[m] = PosW'(st); ne[m] = PosW'(en); nn[m] = it.note; nc[m] = it.chord;
        org[m] = TagNew;
        m++;
        placed = 1'b1;
      end
      if (put_cur && m < Capacity + 1) begin
        ns[m] = cs; ne[m] = ce; nn[m] = tbl_n[i]; nc[m] = tbl_c[i]; org[m] = i;
        m++;
      end
    end
    nq = 0;
    if (kind != KIND_FIRST) begin
      if (kind == KIND_CHOSEN) want = chosen;
      else want = q_removed ? TagNew : q;
      for (int j = m - 1; j >= 0; j--) if (org[j] == want) nq = j;
    end
    if (org[nq] != q) playing = 1'b0;
    for (int j = 0; j < m && j < Capacity; j++) begin
      tbl_s[j] = ns[j]; tbl_e[j] = ne[j]; tbl_n[j] = nn[j]; tbl_c[j] = nc[j];
    end
    tbl_count = m > Capacity ? Capacity : m;
    play_idx = nq;
    return 1'b0;
  endfunction

  function automatic res_t table_predict(item_t it);
    res_t r;
    logic dropped;
    int q;
    dropped = 1'b0;
    if (it.mode == MODE_TICK) begin
      if (tbl_count > 0) begin
        if (play_idx >= tbl_count) play_idx = 0;
        if (!playing) begin
          if (it.pos == tbl_s[play_idx]) playing = 1'b1;
        end else if (it.pos == tbl_e[play_idx]) begin
          playing = 1'b0;
          play_idx = (play_idx + 1 < tbl_count) ? play_idx + 1 : 0;
        end
      end
    end else if (it.mode == MODE_ADD) begin
      dropped = insert_event(it);
    end else if (it.mode == MODE_CLEAR) begin
      tbl_count = 0;
      play_idx = 0;
      playing = 1'b0;
    end
    r = '0;
    if (tbl_count > 0) begin
      q = play_idx < tbl_count ? play_idx : 0;
      r.active = playing;
      r.note = tbl_n[q];
      r.chord = tbl_c[q];
    end
    r.count = CntW'(tbl_count);
    r.dropped = dropped;
    return r;
  endfunction

  // driver: bursts with random gaps
  item_t cur_item;
  logic  holding = 1'b0;
  int    burst_left = 4, gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        expected_status.push_back(table_predict(cur_item));
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          holding = 1'b1;
          mode_d <= cur_item.mode;
          pos_d <= cur_item.pos;
          st_d <= cur_item.st;
          en_d <= cur_item.en;
          note_d <= cur_item.note;
          chord_d <= cur_item.chord;
          push <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stalls on a rotating pattern
  logic [7:0] stall_pat = 8'hff;
  int         pat_age = 0;

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected item: active=%0b note=%0h chord=%0b count=%0d dropped=%0b",
                   $realtime, active_o, current_note_o, current_chord_o, event_count_o,
                   add_dropped_o);
          errors++;
        end else begin
          exp_r = expected_status.pop_front();
          n_checked++;
          if (exp_r.active) n_active++;
          if (exp_r.dropped) n_dropped++;
          if (exp_r.count == Capacity) n_full_tables++;
          if (active_o !== exp_r.active) begin
            $display("%0t: active expected %0b actual %0b", $realtime, exp_r.active, active_o);
            errors++;
          end
          if (current_note_o !== exp_r.note) begin
            $display("%0t: current_note expected %0h actual %0h", $realtime, exp_r.note,
                     current_note_o);
            errors++;
          end
          if (current_chord_o !== exp_r.chord) begin
            $display("%0t: current_chord expected %0b actual %0b", $realtime, exp_r.chord,
                     current_chord_o);
            errors++;
          end
          if (event_count_o !== exp_r.count) begin
            $display("%0t: event_count expected %0d actual %0d", $realtime, exp_r.count,
                     event_count_o);
            errors++;
          end
          if (add_dropped_o !== exp_r.dropped) begin
            $display("%0t: add_dropped expected %0b actual %0b", $realtime, exp_r.dropped,
                     add_dropped_o);
            errors++;
          end
        end
      end
      pat_age++;
      if (pat_age >= 97) begin
        pat_age = 0;
        stall_pat = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom());
        if (stall_pat == 8'h00) stall_pat = 8'h01;
      end
      stall_pat = {stall_pat[0], stall_pat[7:1]};
      pop <= stall_pat[0];
    end
  end

  // stimulus
  int recent_pos[$];

  function automatic item_t make_item(logic [1:0] mode, int pos, int st, int en, int note,
                                      logic chord);
    item_t it;
    it.mode = mode;
    it.pos = PosW'(pos);
    it.st = PosW'(st);
    it.en = PosW'(en);
    it.note = NoteW'(note);
    it.chord = chord;
    return it;
  endfunction

  task automatic queue_add(int st, int en, int note, logic chord);
    pending_items.push_back(make_item(MODE_ADD, $urandom_range(0, 8191), st, en, note, chord));
    recent_pos.push_back(st);
    recent_pos.push_back(en);
    recent_pos.push_back(st + EndBuffer);
    if (recent_pos.size() > 24) recent_pos = recent_pos[recent_pos.size()-24:$];
  endtask

  task automatic queue_tick(int pos);
    pending_items.push_back(make_item(MODE_TICK, pos, $urandom_range(0, 8191),
                                      $urandom_range(0, 8191), $urandom_range(0, 255),
                                      1'($urandom())));
  endtask

  task automatic gen_random(int count);
    int le, r, st, en, k;
    le = loop_end_pulses(model_steps);
    k = 0;
    while (k < count) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // dense fill run, overflows the table
        st = $urandom_range(0, 20);
        for (int j = 0; j < 34; j++) begin
          queue_add((st + j * 7) % 8192, (st + j * 7 + $urandom_range(0, 5)) % 8192,
                    $urandom_range(0, 255), 1'($urandom()));
          queue_tick(recent_pos[$urandom_range(0, recent_pos.size() - 1)]);
        end
        k += 68;
      end else if (r < 38) begin
        st = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, le);
        case ($urandom_range(0, 7))
          0, 1:    en = st;
          2:       en = (st == 0) ? 0 : $urandom_range(0, st - 1);
          3:       en = $urandom_range(0, 8191);
          default: en = (st + $urandom_range(1, 300) > 8191) ? 8191 : st + $urandom_range(1, 300);
        endcase
        queue_add(st, en, $urandom_range(0, 255), 1'($urandom()));
        k++;
      end else if (r < 95) begin
        if (recent_pos.size() > 0 && $urandom_range(0, 9) < 8)
          queue_tick(recent_pos[$urandom_range(0, recent_pos.size() - 1)]);
        else
          queue_tick($urandom_range(0, 8191));
        k++;
      end else if (r < 98) begin
        pending_items.push_back(make_item(MODE_CLEAR, $urandom_range(0, 8191), 0, 0, 0, 1'b0));
        k++;
      end else begin
        pending_items.push_back(make_item(ModeIgnored, $urandom_range(0, 8191),
                                          $urandom_range(0, 8191), $urandom_range(0, 8191),
                                          $urandom_range(0, 255), 1'($urandom())));
        k++;
      end
    end
  endtask

  task automatic drain;
    wait (pending_items.size() == 0 && !holding && expected_status.size() == 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_steps(int steps);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_steps <= StepsW'(steps);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    model_steps = steps;
  endtask

  int step_list[6] = '{0, 64, 127, 1, 0, 0};

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty table, end rules, overlap, playback, ignored mode
    pending_items.push_back(make_item(MODE_CLEAR, 0, 0, 0, 0, 1'b0));
    queue_tick(0);
    queue_add(0, 0, 8'hff, 1'b1);
    queue_tick(0);
    queue_tick(4);
    queue_add(8191, 8191, 8'h00, 1'b0);
    queue_add(500, 20, 8'h81, 1'b1);
    queue_add(100, 200, 8'h12, 1'b0);
    queue_add(150, 300, 8'h34, 1'b1);
    queue_add(40, 120, 8'h56, 1'b0);
    queue_tick(40);
    queue_tick(120);
    queue_add(300, 8191, 8'h78, 1'b0);
    pending_items.push_back(make_item(ModeIgnored, 8191, 8191, 8191, 255, 1'b1));
    queue_tick(8191);
    pending_items.push_back(make_item(MODE_CLEAR, 8191, 8191, 8191, 255, 1'b1));
    gen_random(300);
    drain();
    step_list[4] = $urandom_range(2, 63);
    step_list[5] = $urandom_range(2, 127);
    foreach (step_list[i]) begin
      set_steps(step_list[i]);
      gen_random(260);
      drain();
    end
    $display("checked %0d results: %0d while sounding, %0d refused adds, %0d at full table",
             n_checked, n_active, n_dropped, n_full_tables);
    if (errors == 0) begin
      $display("PASS loop_event_table");
    end else begin
      $display("FAIL loop_event_table");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL loop_event_table");
    $finish;
  end

endmodule

### sim.f
rtl/lpt_pkg.sv
rtl/lpt_ram.sv
rtl/lpt_front.sv
rtl/lpt_back.sv
rtl/loop_event_table.sv
dv/tb_top.sv
